@@ hdl/mtsg_pkg.sv @@
// ----------------------------------------------------------------------------
// mtsg_pkg
// Shared types, constants and the sine table builder for the multi-tone
// sine generator.
// ----------------------------------------------------------------------------
package mtsg_pkg;

   // default structural parameters
   localparam int MAX_CHANNELS_DEF     = 64;
   localparam int PHASE_BITS_DEF       = 32;
   localparam int TABLE_ADDR_BITS_DEF  = 10;
   localparam int FRAME_COUNT_BITS_DEF = 24;

   // fixed field widths
   localparam int STEP_W      = 32;
   localparam int AMP_W       = 15;
   localparam int CHCNT_W     = 7;
   localparam int LIMIT_W     = 24;
   localparam int IDX_W       = 6;
   localparam int SAMPLE_W    = 16;
   localparam int TAB_W       = 15;
   localparam int Q_SHIFT     = 15;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // queue depths (powers of two)
   localparam int DESC_DEPTH = 2;
   localparam int OUT_DEPTH  = 4;

   // register reset values
   localparam logic [STEP_W-1:0]  BASE_STEP_RST    = 32'd26843546;
   localparam logic [STEP_W-1:0]  SPACING_STEP_RST = 32'd26843546;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RST    = 15'd32767;
   localparam logic [CHCNT_W-1:0] CHANNEL_CNT_RST  = 7'd1;
   localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RST = 24'd16000;

   // pi/2 in Q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_STEP     = 3'd0,
      CSR_SPACING_STEP  = 3'd1,
      CSR_AMPLITUDE     = 3'd2,
      CSR_CHANNEL_COUNT = 3'd3,
      CSR_SAMPLE_LIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0]           channel_index;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       frame_end;
      logic                       run_end;
   } rsp_item_type;

   // Quarter-wave entry i: Taylor sum to x^15 in Q2.30, products truncated,
   // then scaled by 32767 with round half up. Elaboration only.
   function automatic logic [TAB_W-1:0] qtab_entry(input int unsigned i,
                                                   input int unsigned a);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = (64'(i) * HALF_PI_Q30) >> a;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      v = ((64'(sum[31:0]) * 64'd32767) + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[TAB_W-1:0];
   endfunction

endpackage

@@ hdl/mtsg_fifo.sv @@
// ----------------------------------------------------------------------------
// mtsg_fifo
// Small synchronous queue with occupancy count; depth must be a power of two.
// ----------------------------------------------------------------------------
module mtsg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [ADDR_W:0]  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W:0]  rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W:0]  used;

   assign used  = wr_ptr_ff - rd_ptr_ff;
   assign count = ($clog2(DEPTH+1))'(used);
   assign empty = (used == '0);
   assign full  = (used == (ADDR_W+1)'(DEPTH));
   assign rdata = mem_ff[rd_ptr_ff[ADDR_W-1:0]];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff[ADDR_W-1:0]] <= wdata;
      end
   end

endmodule

@@ hdl/mtsg_sine_rom.sv @@
// ----------------------------------------------------------------------------
// mtsg_sine_rom
// Quarter-wave unsigned Q0.15 sine table, contents built at elaboration, registered read.
// ----------------------------------------------------------------------------
module mtsg_sine_rom #(
   parameter int TABLE_ADDR_BITS = mtsg_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic [TABLE_ADDR_BITS:0]        addr,
   output logic [mtsg_pkg::TAB_W-1:0]      data
);
   import mtsg_pkg::*;

   localparam int N = 1 << TABLE_ADDR_BITS;

   logic [TAB_W-1:0] rom [N+1];
   logic [TAB_W-1:0] data_ff;

   for (genvar g = 0; g <= N; g++) begin : g_entry
      localparam logic [TAB_W-1:0] VAL = qtab_entry(g, TABLE_ADDR_BITS);
      assign rom[g] = VAL;
   end

   always_ff @(posedge clock) begin
      data_ff <= rom[addr];
   end

   assign data = data_ff;

endmodule

@@ hdl/mtsg_front.sv @@
// ----------------------------------------------------------------------------
// mtsg_front
// Accepts ticks, applies restart and the sample limit, and queues one frame
// descriptor per tick that produces output.
// ----------------------------------------------------------------------------
module mtsg_front #(
   parameter int MAX_CHANNELS     = mtsg_pkg::MAX_CHANNELS_DEF,
   parameter int PHASE_BITS       = mtsg_pkg::PHASE_BITS_DEF,
   parameter int FRAME_COUNT_BITS = mtsg_pkg::FRAME_COUNT_BITS_DEF,
   parameter int J_W              = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   parameter int DESC_W           = 2 * PHASE_BITS + J_W + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           restart,
   input  logic                           desc_full,
   input  logic [PHASE_BITS-1:0]          base_step,
   input  logic [PHASE_BITS-1:0]          spacing_step,
   input  logic [mtsg_pkg::CHCNT_W-1:0]   channel_count,
   input  logic [mtsg_pkg::LIMIT_W-1:0]   sample_limit,
   output logic                           desc_push,
   output logic [DESC_W-1:0]              desc_data
);
   import mtsg_pkg::*;

   localparam int CMP_W = ((FRAME_COUNT_BITS > LIMIT_W) ? FRAME_COUNT_BITS : LIMIT_W) + 1;

   logic [PHASE_BITS-1:0]       base_acc_ff, base_acc_in;
   logic [PHASE_BITS-1:0]       spacing_acc_ff, spacing_acc_in;
   logic [FRAME_COUNT_BITS-1:0] frames_ff, frames_in;

   logic                        accept;
   logic [PHASE_BITS-1:0]       base_now;
   logic [PHASE_BITS-1:0]       spacing_now;
   logic [FRAME_COUNT_BITS-1:0] frames_now;
   logic [CMP_W-1:0]            frames_ext;
   logic [CMP_W-1:0]            limit_ext;
   logic                        limit_on;
   logic                        stopped;
   logic                        last_frame;
   logic [J_W-1:0]              last_j;

   assign accept = push && !desc_full;

   always_comb begin
      base_now    = restart ? '0 : base_acc_ff;
      spacing_now = restart ? '0 : spacing_acc_ff;
      frames_now  = restart ? '0 : frames_ff;
      frames_ext  = CMP_W'(frames_now);
      limit_ext   = CMP_W'(sample_limit);
      limit_on    = (sample_limit != '0);
      stopped     = limit_on && (frames_ext >= limit_ext);
      last_frame  = limit_on && ((frames_ext + 1'b1) == limit_ext);

      // zero channels behaves as one, too many saturates
      if (channel_count == '0) begin
         last_j = '0;
      end else if (int'(channel_count) > MAX_CHANNELS) begin
         last_j = J_W'(MAX_CHANNELS - 1);
      end else begin
         last_j = J_W'(channel_count - 1'b1);
      end

      base_acc_in    = base_acc_ff;
      spacing_acc_in = spacing_acc_ff;
      frames_in      = frames_ff;
      desc_push      = 1'b0;
      if (accept) begin
         base_acc_in    = base_now;
         spacing_acc_in = spacing_now;
         frames_in      = frames_now;
         if (!stopped) begin
            desc_push      = 1'b1;
            base_acc_in    = base_now + base_step;
            spacing_acc_in = spacing_now + spacing_step;
            frames_in      = frames_now + 1'b1;
         end
      end
      desc_data = {base_now, spacing_now, last_j, last_frame};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_acc_ff    <= '0;
         spacing_acc_ff <= '0;
         frames_ff      <= '0;
      end else begin
         base_acc_ff    <= base_acc_in;
         spacing_acc_ff <= spacing_acc_in;
         frames_ff      <= frames_in;
      end
   end

endmodule

@@ hdl/mtsg_back.sv @@
// ----------------------------------------------------------------------------
// mtsg_back
// Walks the channels of one frame descriptor, one per cycle: phase step,
// table read, amplitude multiply, sign. Issue is held back by output credit.
// ----------------------------------------------------------------------------
module mtsg_back #(
   parameter int MAX_CHANNELS    = mtsg_pkg::MAX_CHANNELS_DEF,
   parameter int PHASE_BITS      = mtsg_pkg::PHASE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = mtsg_pkg::TABLE_ADDR_BITS_DEF,
   parameter int J_W             = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   parameter int DESC_W          = 2 * PHASE_BITS + J_W + 1,
   parameter int OUT_CNT_W       = $clog2(mtsg_pkg::OUT_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        desc_empty,
   input  logic [DESC_W-1:0]           desc_data,
   output logic                        desc_pop,
   input  logic [mtsg_pkg::AMP_W-1:0]  amplitude,
   input  logic [OUT_CNT_W-1:0]        out_count,
   output logic                        out_push,
   output mtsg_pkg::rsp_item_type      out_item
);
   import mtsg_pkg::*;

   localparam int A      = TABLE_ADDR_BITS;
   localparam int PROD_W = AMP_W + TAB_W;

   // current frame
   logic                  busy_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] spacing_ff;
   logic [J_W-1:0]        j_ff;
   logic [J_W-1:0]        last_j_ff;
   logic                  last_frame_ff;

   // stage 1: table read in flight
   logic                  v1_ff;
   logic                  neg1_ff;
   logic [J_W-1:0]        j1_ff;
   logic                  fe1_ff;
   logic                  re1_ff;

   // stage 2: product
   logic                  v2_ff;
   logic                  neg2_ff;
   logic [J_W-1:0]        j2_ff;
   logic                  fe2_ff;
   logic                  re2_ff;
   logic [PROD_W-1:0]     prod2_ff;

   logic [PHASE_BITS-1:0] d_base;
   logic [PHASE_BITS-1:0] d_spacing;
   logic [J_W-1:0]        d_last_j;
   logic                  d_last_frame;

   logic [OUT_CNT_W:0]    pending;
   logic                  issue;
   logic                  frame_done;
   logic                  can_load;
   logic [1:0]            quad;
   logic [A-1:0]          idx;
   logic [A:0]            addr;
   logic [TAB_W-1:0]      rom_data;
   logic [AMP_W-1:0]      mag;
   logic [SAMPLE_W-1:0]   mag_ext;

   assign {d_base, d_spacing, d_last_j, d_last_frame} = desc_data;

   // results already owed to the output queue count against its room
   assign pending    = (OUT_CNT_W+1)'(out_count) + (OUT_CNT_W+1)'(v1_ff)
                     + (OUT_CNT_W+1)'(v2_ff);
   assign issue      = busy_ff && (int'(pending) < OUT_DEPTH);
   assign frame_done = issue && (j_ff == last_j_ff);
   assign can_load   = !busy_ff || frame_done;
   assign desc_pop   = can_load && !desc_empty;

   assign quad = phase_ff[PHASE_BITS-1 -: 2];
   assign idx  = phase_ff[PHASE_BITS-3 -: A];
   assign addr = quad[0] ? ({1'b1, {A{1'b0}}} - {1'b0, idx}) : {1'b0, idx};

   mtsg_sine_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_rom (
      .clock (clock),
      .addr  (addr),
      .data  (rom_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         if (desc_pop) begin
            busy_ff <= 1'b1;
         end else if (frame_done) begin
            busy_ff <= 1'b0;
         end
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_pop) begin
         phase_ff      <= d_base;
         spacing_ff    <= d_spacing;
         j_ff          <= '0;
         last_j_ff     <= d_last_j;
         last_frame_ff <= d_last_frame;
      end else if (issue) begin
         phase_ff <= phase_ff + spacing_ff;
         j_ff     <= j_ff + 1'b1;
      end
      neg1_ff  <= quad[1];
      j1_ff    <= j_ff;
      fe1_ff   <= (j_ff == last_j_ff);
      re1_ff   <= last_frame_ff;
      neg2_ff  <= neg1_ff;
      j2_ff    <= j1_ff;
      fe2_ff   <= fe1_ff;
      re2_ff   <= re1_ff;
      prod2_ff <= amplitude * rom_data;
   end

   assign mag     = prod2_ff[PROD_W-1 -: AMP_W];
   assign mag_ext = SAMPLE_W'(mag);

   always_comb begin
      out_push               = v2_ff;
      out_item.channel_index = IDX_W'(j2_ff);
      out_item.sample_value  = neg2_ff ? -mag_ext : mag_ext;
      out_item.frame_end     = fe2_ff;
      out_item.run_end       = re2_ff;
   end

endmodule

@@ hdl/multi_tone_sine_generator.sv @@
// ----------------------------------------------------------------------------
// multi_tone_sine_generator
// Multi-channel DDS: each tick taken within the sample limit yields one frame of sine samples,
// one per channel, at a common amplitude.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         push / full           req_restart
//  rsp       out        empty / pop           rsp_channel_index, rsp_sample_value,
//                                             rsp_frame_end, rsp_run_end
//  csr       in         csr_we (no wait)      csr_index, csr_wdata
//
//  A frame of C channels occupies the shared table read and multiplier, one
//  sample per cycle while output credit lasts; back-to-back frames have no gap.
//  A taken tick passes the frame queue and the phase, table and product registers.
//  Ticks are queued (two frames deep) ahead of the sample pipeline; pop stalls
//  back up through a four-entry result queue. Ticks past the limit give nothing.
//  Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
module multi_tone_sine_generator #(
   parameter int MAX_CHANNELS     = mtsg_pkg::MAX_CHANNELS_DEF,
   parameter int PHASE_BITS       = mtsg_pkg::PHASE_BITS_DEF,
   parameter int TABLE_ADDR_BITS  = mtsg_pkg::TABLE_ADDR_BITS_DEF,
   parameter int FRAME_COUNT_BITS = mtsg_pkg::FRAME_COUNT_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic                                   req_restart,
   output logic                                   empty,
   input  logic                                   pop,
   output logic [mtsg_pkg::IDX_W-1:0]             rsp_channel_index,
   output logic signed [mtsg_pkg::SAMPLE_W-1:0]   rsp_sample_value,
   output logic                                   rsp_frame_end,
   output logic                                   rsp_run_end,
   input  logic                                   csr_we,
   input  logic [mtsg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mtsg_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import mtsg_pkg::*;

   localparam int J_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DESC_W    = 2 * PHASE_BITS + J_W + 1;
   localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int ITEM_W    = $bits(rsp_item_type);

   logic [PHASE_BITS-1:0] base_step_ff;
   logic [PHASE_BITS-1:0] spacing_step_ff;
   logic [AMP_W-1:0]      amplitude_ff;
   logic [CHCNT_W-1:0]    channel_count_ff;
   logic [LIMIT_W-1:0]    sample_limit_ff;

   logic                  desc_push;
   logic                  desc_pop;
   logic                  desc_empty;
   logic                  desc_full;
   logic [DESC_W-1:0]     desc_wdata;
   logic [DESC_W-1:0]     desc_rdata;
   logic [DESC_CNT_W-1:0] desc_count;

   logic                  out_push;
   logic                  out_full;
   logic [OUT_CNT_W-1:0]  out_count;
   rsp_item_type          out_item;
   rsp_item_type          rsp_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff     <= PHASE_BITS'(BASE_STEP_RST);
         spacing_step_ff  <= PHASE_BITS'(SPACING_STEP_RST);
         amplitude_ff     <= AMPLITUDE_RST;
         channel_count_ff <= CHANNEL_CNT_RST;
         sample_limit_ff  <= SAMPLE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_STEP:     base_step_ff     <= PHASE_BITS'(csr_wdata[STEP_W-1:0]);
            CSR_SPACING_STEP:  spacing_step_ff  <= PHASE_BITS'(csr_wdata[STEP_W-1:0]);
            CSR_AMPLITUDE:     amplitude_ff     <= csr_wdata[AMP_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHCNT_W-1:0];
            CSR_SAMPLE_LIMIT:  sample_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   mtsg_front #(
      .MAX_CHANNELS     (MAX_CHANNELS),
      .PHASE_BITS       (PHASE_BITS),
      .FRAME_COUNT_BITS (FRAME_COUNT_BITS),
      .J_W              (J_W),
      .DESC_W           (DESC_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .restart       (req_restart),
      .desc_full     (desc_full),
      .base_step     (base_step_ff),
      .spacing_step  (spacing_step_ff),
      .channel_count (channel_count_ff),
      .sample_limit  (sample_limit_ff),
      .desc_push     (desc_push),
      .desc_data     (desc_wdata)
   );

   mtsg_fifo #(
      .WIDTH (DESC_W),
      .DEPTH (DESC_DEPTH)
   ) u_desc_q (
      .clock (clock),
      .reset (reset),
      .push  (desc_push),
      .wdata (desc_wdata),
      .pop   (desc_pop),
      .rdata (desc_rdata),
      .empty (desc_empty),
      .full  (desc_full),
      .count (desc_count)
   );

   mtsg_back #(
      .MAX_CHANNELS    (MAX_CHANNELS),
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .J_W             (J_W),
      .DESC_W          (DESC_W),
      .OUT_CNT_W       (OUT_CNT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_empty (desc_empty),
      .desc_data  (desc_rdata),
      .desc_pop   (desc_pop),
      .amplitude  (amplitude_ff),
      .out_count  (out_count),
      .out_push   (out_push),
      .out_item   (out_item)
   );

   mtsg_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_item),
      .pop   (pop),
      .rdata (rsp_item),
      .empty (empty),
      .full  (out_full),
      .count (out_count)
   );

   assign full              = desc_full;
   assign rsp_channel_index = rsp_item.channel_index;
   assign rsp_sample_value  = rsp_item.sample_value;
   assign rsp_frame_end     = rsp_item.frame_end;
   assign rsp_run_end       = rsp_item.run_end;

   // credit scheme must never overrun the result queue
   a_out_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue written while full");

   // back end only takes a frame that is there
   a_desc_pop_valid: assert property (@(posedge clock) disable iff (reset)
      desc_pop |-> (!desc_empty && (desc_count != '0)))
      else $error("frame queue read while empty");

   // nothing is offered straight after reset
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> empty)
      else $error("result offered right after reset");

endmodule

@@ tb/sv/tone_frame_checker.sv @@
// ----------------------------------------------------------------------------
// tone_frame_checker
// Watches the tick, sample and register channels of the multi-tone sine
// generator, predicts every sample frame from its own copy of the state and
// registers, and compares each popped sample with the oldest prediction.
// ----------------------------------------------------------------------------
module tone_frame_checker
   import mtsg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic                       full,
   input  logic                       req_restart,
   input  logic                       empty,
   input  logic                       pop,
   input  logic [IDX_W-1:0]           rsp_channel_index,
   input  logic signed [SAMPLE_W-1:0] rsp_sample_value,
   input  logic                       rsp_frame_end,
   input  logic                       rsp_run_end,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         frames_predicted
);

   localparam int          QUARTER_ADDR_W = 10;
   localparam int          QUARTER_SIZE   = 1 << QUARTER_ADDR_W;
   localparam logic [63:0] HALF_PI_FIXED  = 64'd1686629713;
   localparam int          CHANNEL_CEIL   = 64;
   localparam int          REPORT_LIMIT   = 10;

   localparam logic [31:0]        BASE_STEP_INIT    = 32'd26843546;
   localparam logic [31:0]        SPACING_STEP_INIT = 32'd26843546;
   localparam logic [AMP_W-1:0]   AMP_INIT          = 15'd32767;
   localparam logic [CHCNT_W-1:0] CHANNELS_INIT     = 7'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_INIT        = 24'd16000;

   logic [TAB_W-1:0]   quarter_wave [0:QUARTER_SIZE];

   logic [31:0]        base_step    = BASE_STEP_INIT;
   logic [31:0]        spacing_step = SPACING_STEP_INIT;
   logic [AMP_W-1:0]   amp_level    = AMP_INIT;
   logic [CHCNT_W-1:0] chan_setting = CHANNELS_INIT;
   logic [LIMIT_W-1:0] frame_limit  = LIMIT_INIT;

   logic [31:0]        base_acc     = '0;
   logic [31:0]        spacing_acc  = '0;
   logic [LIMIT_W-1:0] frames_done  = '0;

   rsp_item_type       expected_samples [$];
   int                 mismatches   = 0;
   int                 frames_total = 0;

   // Taylor series to x^15 in Q2.30, each product truncated
   function automatic logic [31:0] taylor_sine_q30(input logic [63:0] x);
      logic [63:0] x_sq;
      logic [63:0] term;
      logic [63:0] sum;
      x_sq = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum[31:0];
   endfunction

   initial begin : build_quarter_wave
      logic [63:0] x;
      logic [63:0] scaled;
      for (int i = 0; i <= QUARTER_SIZE; i++) begin
         x      = (64'(i) * HALF_PI_FIXED) >> QUARTER_ADDR_W;
         scaled = (64'(taylor_sine_q30(x)) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (scaled > 64'd32767) begin
            scaled = 64'd32767;
         end
         quarter_wave[i] = scaled[TAB_W-1:0];
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] tone_value(input logic [31:0]      phase,
                                                             input logic [AMP_W-1:0] amp);
      logic [QUARTER_ADDR_W:0] addr;
      logic [TAB_W-1:0]        mag;
      logic [2*AMP_W-1:0]      product;
      logic [SAMPLE_W-1:0]     level;
      addr = {1'b0, phase[29:20]};
      // odd quadrants run the table backwards, so the index can reach the top entry
      if (phase[30]) begin
         addr = (QUARTER_ADDR_W + 1)'(QUARTER_SIZE) - addr;
      end
      mag     = quarter_wave[addr];
      product = amp * mag;
      level   = {1'b0, product[2*AMP_W-1:Q_SHIFT]};
      return phase[31] ? -level : level;
   endfunction

   task automatic predict_frame(input logic restart);
      int           chans;
      logic         last_frame;
      logic [31:0]  phase;
      rsp_item_type sample;
      if (restart) begin
         base_acc    = '0;
         spacing_acc = '0;
         frames_done = '0;
      end
      // limit reached (or lowered below the count): tick is swallowed
      if (frame_limit != 0 && frames_done >= frame_limit) begin
         return;
      end
      chans = (chan_setting == 0) ? 1 :
              (chan_setting > CHANNEL_CEIL) ? CHANNEL_CEIL : int'(chan_setting);
      last_frame = (frame_limit != 0) &&
                   ({1'b0, frames_done} + 25'd1 == {1'b0, frame_limit});
      for (int j = 0; j < chans; j++) begin
         phase                = base_acc + 32'(j) * spacing_acc;
         sample.channel_index = IDX_W'(j);
         sample.sample_value  = tone_value(phase, amp_level);
         sample.frame_end     = (j == chans - 1);
         sample.run_end       = last_frame;
         expected_samples.push_back(sample);
      end
      base_acc     = base_acc + base_step;
      spacing_acc  = spacing_acc + spacing_step;
      frames_done  = frames_done + 1'b1;
      frames_total = frames_total + 1;
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         base_step    = BASE_STEP_INIT;
         spacing_step = SPACING_STEP_INIT;
         amp_level    = AMP_INIT;
         chan_setting = CHANNELS_INIT;
         frame_limit  = LIMIT_INIT;
         base_acc     = '0;
         spacing_acc  = '0;
         frames_done  = '0;
         expected_samples.delete();
      end else begin
         if (pop && !empty) begin
            seen.channel_index = rsp_channel_index;
            seen.sample_value  = rsp_sample_value;
            seen.frame_end     = rsp_frame_end;
            seen.run_end       = rsp_run_end;
            if (expected_samples.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%0t: unexpected sample ch %0d val %0d fe %0b re %0b", $time,
                           seen.channel_index, seen.sample_value, seen.frame_end,
                           seen.run_end);
               end
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (seen !== want) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("%0t: sample mismatch, expected ch %0d val %0d fe %0b re %0b",
                              $time, want.channel_index, want.sample_value,
                              want.frame_end, want.run_end);
                     $display("%0t:                  actual ch %0d val %0d fe %0b re %0b",
                              $time, seen.channel_index, seen.sample_value,
                              seen.frame_end, seen.run_end);
                  end
                  mismatches++;
               end
            end
         end
         if (push && !full) begin
            predict_frame(req_restart);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_STEP:     base_step    = csr_wdata;
               CSR_SPACING_STEP:  spacing_step = csr_wdata;
               CSR_AMPLITUDE:     amp_level    = csr_wdata[AMP_W-1:0];
               CSR_CHANNEL_COUNT: chan_setting = csr_wdata[CHCNT_W-1:0];
               CSR_SAMPLE_LIMIT:  frame_limit  = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count   <= mismatches;
      pending_count    <= expected_samples.size();
      frames_predicted <= frames_total;
   end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the multi-tone sine generator: a directed opening over the
// register extremes and limit handling, then randomised register phases with
// bursty ticks and a stalling sample consumer. Checking sits in the checker.
// ----------------------------------------------------------------------------
module tb_top;
   import mtsg_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_TICKS  = 256;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_BURST     = 12;
   localparam int MAX_GAP       = 12;
   localparam int MAX_STALL     = 8;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       push        = 1'b0;
   logic                       req_restart = 1'b0;
   logic                       pop         = 1'b0;
   logic                       csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index   = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata   = '0;
   logic                       full;
   logic                       empty;
   logic [IDX_W-1:0]           rsp_channel_index;
   logic signed [SAMPLE_W-1:0] rsp_sample_value;
   logic                       rsp_frame_end;
   logic                       rsp_run_end;

   int mismatch_count;
   int pending_count;
   int frames_predicted;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_left  = 0;
   int mode_left   = 0;
   bit choppy      = 1'b0;

   multi_tone_sine_generator u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_restart       (req_restart),
      .empty             (empty),
      .pop               (pop),
      .rsp_channel_index (rsp_channel_index),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_run_end       (rsp_run_end),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   tone_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_restart       (req_restart),
      .empty             (empty),
      .pop               (pop),
      .rsp_channel_index (rsp_channel_index),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_run_end       (rsp_run_end),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .frames_predicted  (frames_predicted)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // consumer alternates between free-running and choppy stretches
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            choppy    <= 1'($urandom_range(0, 1));
            mode_left <= $urandom_range(50, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (stall_left != 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            pop <= 1'b1;
            if (choppy && $urandom_range(0, 3) == 0) begin
               stall_left <= $urandom_range(1, MAX_STALL);
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // caller stands at a rising edge; csr_we is left high for a following write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] base, input logic [31:0] spacing,
                            input logic [31:0] amp, input logic [31:0] chans,
                            input logic [31:0] limit);
      write_reg(CSR_BASE_STEP, base);
      write_reg(CSR_SPACING_STEP, spacing);
      write_reg(CSR_AMPLITUDE, amp);
      write_reg(CSR_CHANNEL_COUNT, chans);
      write_reg(CSR_SAMPLE_LIMIT, limit);
      write_reg(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), $urandom);
      csr_we <= 1'b0;
   endtask

   task automatic send_tick(input logic restart);
      int gap;
      push        <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (full) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, MAX_BURST);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off until every predicted sample is out, then let stray ticks settle
   task automatic drain(input int settle);
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h4000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] amp_word;
      logic [31:0] chan_word;
      logic [31:0] limit_word;
      int          ticks_left;
      int          phase_goal;
      bit          first_tick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      repeat (2) send_tick(1'b0);

      // quarter-turn steps land on every quadrant boundary
      drain(SETTLE_CYCLES);
      configure(32'h4000_0000, 32'h4000_0000, 32'd32767, 32'd4, 32'd0);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);

      // zero amplitude, zero channels taken as one
      drain(SETTLE_CYCLES);
      configure(32'h0123_4567, 32'h0800_0000, 32'd0, 32'd0, 32'd0);
      send_tick(1'b0);

      // full-scale steps, channel count saturating, short limit then restart
      drain(SETTLE_CYCLES);
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_007F, 32'd3);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      send_tick(1'b1);

      // continuous run, then limit dropped below the frame count
      drain(SETTLE_CYCLES);
      configure(32'h1234_5678, 32'h0001_0000, 32'd12345, 32'd64, 32'd0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      drain(SETTLE_CYCLES);
      configure(32'h1234_5678, 32'h0001_0000, 32'd12345, 32'd64, 32'd2);
      send_tick(1'b0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);

      // limit of one: the first frame is also the last
      drain(SETTLE_CYCLES);
      configure(32'h0000_0000, 32'h2000_0000, 32'd20000, 32'd2, 32'd1);
      send_tick(1'b1);
      send_tick(1'b0);
      drain(SETTLE_CYCLES);

      ticks_left = RANDOM_TICKS;
      while (ticks_left > 0) begin
         amp_word = $urandom;
         case ($urandom_range(0, 4))
            0:       amp_word[AMP_W-1:0] = '0;
            1:       amp_word[AMP_W-1:0] = '1;
            default: ;
         endcase
         chan_word = $urandom;
         case ($urandom_range(0, 9))
            0:       chan_word[CHCNT_W-1:0] = '0;
            1:       chan_word[CHCNT_W-1:0] = 7'd64;
            2:       chan_word[CHCNT_W-1:0] = CHCNT_W'($urandom_range(65, 127));
            default: chan_word[CHCNT_W-1:0] = CHCNT_W'($urandom_range(1, 8));
         endcase
         limit_word = $urandom;
         case ($urandom_range(0, 4))
            0:       limit_word[LIMIT_W-1:0] = '0;
            1:       limit_word[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 5));
            2:       limit_word[LIMIT_W-1:0] = LIMIT_W'($urandom_range(6, 60));
            3:       limit_word[LIMIT_W-1:0] = '1;
            default: ;
         endcase
         configure(pick_step(), pick_step(), amp_word, chan_word, limit_word);

         // accumulators carry over from the previous phase unless restarted
         phase_goal = frames_predicted + $urandom_range(15, 45);
         first_tick = 1'b1;
         while (frames_predicted < phase_goal && ticks_left > 0) begin
            send_tick(first_tick ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0));
            first_tick = 1'b0;
            ticks_left--;
            if ($urandom_range(0, 59) == 0) begin
               drain(0);
            end
         end
         drain(SETTLE_CYCLES);
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
